// ----- design/dss_pkg.sv -----
// ============================================================================
// Descending score sorter package
// Entry layout used by the sorter; its storage is sized by the entry width.
// ============================================================================
package dss_pkg;

    localparam int SCORE_W = 32;
    localparam int TAG_W   = 16;

    // One stored entry: score in the low bits, tag above it.
    typedef struct packed {
        logic [TAG_W-1:0]          tag;
        logic signed [SCORE_W-1:0] score;
    } dss_entry_t;

    localparam int ENTRY_W = $bits(dss_entry_t);

endpackage

// ----- design/descending_score_sorter.sv -----
// An entry walks down from the end in the insert state, moving each lower score up, and is
// written when it stops behind a score that is not lower, or in the place state when it goes
// to the front; an entry into an empty batch, or a dropped one, is handled at its transfer.
// A closing entry then yields its batch one result at a time, each read from the RAM and
// then loaded into the output stage once it has room. Throughput: one entry at a time; the
// next transfer is taken once filing ends. Reset (aresetn low, synchronous) clears the count,
// the drop flag, the state and the output valid; the entry RAM is not cleared and needs no pass.
// ============================================================================
// Descending score sorter
// Collects a batch of tagged scores and emits it ordered high to low.
// ============================================================================
module descending_score_sorter
    import dss_pkg::*;
#(
    parameter int MAX_ENTRIES = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Input stream.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [ENTRY_W-1:0]   s_tdata,   // [31:0] score, [47:32] tag
    input  logic                 s_tlast,   // last_item
    // Result stream.
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [ENTRY_W-1:0]   m_tdata,   // [31:0] sorted_score, [47:32] sorted_tag
    output logic                 m_tlast,   // last_result
    output logic                 m_tuser    // [0] overflow
);

    // Address width of the entry RAM and width of the fill count, which must
    // also hold MAX_ENTRIES itself.
    localparam int AW = $clog2(MAX_ENTRIES);
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    // Controller states.
    localparam logic [2:0] ST_IDLE    = 3'd0;  // waiting for an entry
    localparam logic [2:0] ST_INSERT  = 3'd1;  // shifting lower scores up
    localparam logic [2:0] ST_PLACE   = 3'd2;  // new entry goes to the front
    localparam logic [2:0] ST_EMIT_RD = 3'd3;  // read the next ranked entry
    localparam logic [2:0] ST_EMIT_LD = 3'd4;  // move it into the output stage

    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic          dropped_reg, dropped_next;
    logic [AW-1:0] pos_reg, pos_next;
    logic [AW-1:0] emit_idx_reg, emit_idx_next;
    dss_entry_t    new_reg, new_next;
    logic          new_last_reg, new_last_next;

    // Output stage: holds a finished result while the next ranked entry is read.
    logic          m_valid_reg, m_valid_next;
    dss_entry_t    m_data_reg, m_data_next;
    logic          m_last_reg, m_last_next;
    logic          m_user_reg, m_user_next;

    // RAM ports.
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    dss_entry_t    wr_data;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [ENTRY_W-1:0] rd_raw;
    dss_entry_t    rd_entry;

    dss_entry_t    in_entry;
    logic          s_xfer;
    logic          out_free;
    logic          emit_final;

    assign in_entry = dss_entry_t'(s_tdata);
    assign rd_entry = dss_entry_t'(rd_raw);
    assign s_tready = (state_reg == ST_IDLE);
    assign s_xfer   = s_tvalid && s_tready;
    // The output stage can take a result when it is empty or being drained.
    assign out_free = !m_valid_reg || m_tready;
    assign emit_final = ((CW'(emit_idx_reg) + CW'(1)) == count_reg);

    // The RAM is kept sorted, highest score at address 0. A new entry is
    // filed by walking down from the end: every stored entry with a strictly
    // lower score moves one place up, which keeps equal scores in arrival
    // order. Each step reads the next lower address while writing the hole
    // left above it, so a read and a write never hit the same entry.
    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        dropped_next  = dropped_reg;
        pos_next      = pos_reg;
        emit_idx_next = emit_idx_reg;
        new_next      = new_reg;
        new_last_next = new_last_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;
        m_last_next   = m_last_reg;
        m_user_next   = m_user_reg;
        wr_en         = 1'b0;
        wr_addr       = pos_reg;
        wr_data       = new_reg;
        rd_en         = 1'b0;
        rd_addr       = pos_reg;

        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    new_next      = in_entry;
                    new_last_next = s_tlast;
                    emit_idx_next = '0;
                    if (count_reg == CW'(MAX_ENTRIES)) begin
                        // Batch full: the entry is dropped.
                        dropped_next = 1'b1;
                        if (s_tlast) begin
                            state_next = ST_EMIT_RD;
                        end
                    end else if (count_reg == '0) begin
                        // Empty batch: file straight into the first place.
                        wr_en      = 1'b1;
                        wr_addr    = '0;
                        wr_data    = in_entry;
                        count_next = CW'(1);
                        if (s_tlast) begin
                            state_next = ST_EMIT_RD;
                        end
                    end else begin
                        pos_next   = count_reg[AW-1:0];
                        rd_en      = 1'b1;
                        rd_addr    = AW'(count_reg - CW'(1));
                        state_next = ST_INSERT;
                    end
                end
            end

            ST_INSERT: begin
                // rd_entry holds the entry just below the hole at pos_reg.
                wr_en   = 1'b1;
                wr_addr = pos_reg;
                if (rd_entry.score < new_reg.score) begin
                    wr_data  = rd_entry;
                    pos_next = pos_reg - AW'(1);
                    if (pos_reg == AW'(1)) begin
                        state_next = ST_PLACE;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = pos_reg - AW'(2);
                    end
                end else begin
                    wr_data    = new_reg;
                    count_next = count_reg + CW'(1);
                    state_next = new_last_reg ? ST_EMIT_RD : ST_IDLE;
                end
            end

            ST_PLACE: begin
                wr_en      = 1'b1;
                wr_addr    = pos_reg;
                wr_data    = new_reg;
                count_next = count_reg + CW'(1);
                state_next = new_last_reg ? ST_EMIT_RD : ST_IDLE;
            end

            ST_EMIT_RD: begin
                rd_en      = 1'b1;
                rd_addr    = emit_idx_reg;
                state_next = ST_EMIT_LD;
            end

            ST_EMIT_LD: begin
                // The read data holds until the output stage has room.
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = rd_entry;
                    m_last_next  = emit_final;
                    m_user_next  = dropped_reg;
                    if (emit_final) begin
                        count_next   = '0;
                        dropped_next = 1'b0;
                        state_next   = ST_IDLE;
                    end else begin
                        emit_idx_next = emit_idx_reg + AW'(1);
                        state_next    = ST_EMIT_RD;
                    end
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            dropped_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            dropped_reg <= dropped_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg      <= pos_next;
        emit_idx_reg <= emit_idx_next;
        new_reg      <= new_next;
        new_last_reg <= new_last_next;
        m_data_reg   <= m_data_next;
        m_last_reg   <= m_last_next;
        m_user_reg   <= m_user_next;
    end

    dss_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(MAX_ENTRIES)
    ) u_entry_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_raw)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_user_reg;

endmodule

// ----- design/dss_ram.sv -----
// ============================================================================
// Generic simple dual-port RAM
// One write port and one read port with a registered, enabled read.
// ============================================================================
module dss_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 32
) (
    input  logic                                   aclk,
    input  logic                                   wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
